FILE: rtl/bdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int          DEPTH_DEF = 16;
	localparam int          CW        = 5;
	localparam logic [CW-1:0] CAP_RESET = 5'd16;

	localparam logic [2:0] OP_NONE      = 3'd0;
	localparam logic [2:0] OP_INS_FRONT = 3'd1;
	localparam logic [2:0] OP_INS_BACK  = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_BACK  = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               success;
		logic signed [31:0] front_value;
		logic signed [31:0] rear_value;
		logic               is_empty;
		logic               is_full;
		logic [CW-1:0]      occupancy;
	} rsp_t;

	typedef struct packed {
		logic exec;
		logic rd;
		logic load;
	} cmd_t;

endpackage
`default_nettype wire

FILE: rtl/bdq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept request, read front and rear slots, load response.
// ----------------------------------------------------------------------------
module bdq_ctrl
	import bdq_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  wire  rsp_ready,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_LD   = 2'd2;

	logic [1:0] state_q;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.exec = req_valid && req_ready;
		cmd.rd   = (state_q == S_RD);
		cmd.load = (state_q == S_LD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bdq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_dp
// Ring buffer datapath: slot memory, head/tail/count, capacity, response reg.
// ----------------------------------------------------------------------------
module bdq_dp
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  cmd_t          cmd,
	input  req_t          req,
	input  wire           cfg_we,
	input  wire  [CW-1:0] cfg_data,
	output rsp_t          rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_SAT = (DEPTH > 31) ? 5'd31 : CW'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] i);
		return (i == '0) ? LAST_IDX : i - 1'b1;
	endfunction

	logic [31:0]   mem [DEPTH];
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q, cap_q, cap_eff;
	logic          success_q;
	logic [31:0]   front_q, rear_q;
	rsp_t          rsp_q;

	logic          can_ins, can_del, wr_en;
	logic [IW-1:0] wr_addr;

	assign cap_eff = (cap_q > DEPTH_SAT) ? DEPTH_SAT : cap_q;
	assign can_ins = (count_q < cap_eff);
	assign can_del = (count_q != '0);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tail_q;
		if (cmd.exec && can_ins) begin
			if (req.op == OP_INS_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = ring_dec(head_q);
			end else if (req.op == OP_INS_BACK) begin
				wr_en   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= req.value;
		if (cmd.rd) begin
			front_q <= mem[head_q];
			rear_q  <= mem[ring_dec(tail_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			success_q <= 1'b0;
		end else if (cmd.exec) begin
			success_q <= 1'b0;
			unique case (req.op)
				OP_INS_FRONT: begin
					if (can_ins) begin
						head_q    <= ring_dec(head_q);
						count_q   <= count_q + 1'b1;
						success_q <= 1'b1;
					end
				end
				OP_INS_BACK: begin
					if (can_ins) begin
						tail_q    <= ring_inc(tail_q);
						count_q   <= count_q + 1'b1;
						success_q <= 1'b1;
					end
				end
				OP_DEL_FRONT: begin
					if (can_del) begin
						head_q    <= ring_inc(head_q);
						count_q   <= count_q - 1'b1;
						success_q <= 1'b1;
					end
				end
				OP_DEL_BACK: begin
					if (can_del) begin
						tail_q    <= ring_dec(tail_q);
						count_q   <= count_q - 1'b1;
						success_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.success     <= success_q;
			rsp_q.front_value <= can_del ? front_q : '1;
			rsp_q.rear_value  <= can_del ? rear_q : '1;
			rsp_q.is_empty    <= !can_del;
			rsp_q.is_full     <= !can_ins;
			rsp_q.occupancy   <= count_q;
		end
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

FILE: rtl/bounded_double_ended_queue.sv
`default_nettype none
// A response becomes valid once its request has passed the slot-read and
// load states; the load waits while an earlier response is not yet taken.
// No new request is accepted until the response register has been loaded.
// The response register holds a result while the next request is taken.
// Reset: head, tail and count clear, capacity returns to 16; slot memory
// is not cleared.
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Circular deque of signed 32-bit values with configurable capacity.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           req_valid,
	output logic          req_ready,
	input  req_t          req,
	output logic          rsp_valid,
	input  wire           rsp_ready,
	output rsp_t          rsp,
	input  wire           cfg_valid,
	output logic          cfg_ready,
	input  wire  [CW-1:0] cfg_data
);

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp      (rsp)
	);

`ifndef ASSERT_OFF
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.occupancy == '0)))
		else $error("is_empty disagrees with occupancy");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_empty) |->
		(rsp.front_value == -32'sd1 && rsp.rear_value == -32'sd1))
		else $error("empty queue reports stored values");

	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.occupancy == 5'd1) |-> (rsp.front_value == rsp.rear_value))
		else $error("single entry has differing front and rear");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous one in progress");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded double-ended queue. A clocked driver
// sends operation requests and capacity writes from a planned list, a clocked
// monitor takes responses with random back-pressure, and a local deque model
// predicts every response field for field.
// ----------------------------------------------------------------------------
module testbench;
	import bdq_pkg::*;

	localparam int LIMIT = 200000;
	localparam int HOLD  = 8;
	localparam int TAIL  = 12;

	localparam logic [2:0] OP_RSV5 = 3'd5;
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;

	typedef enum { PLAN_OP, PLAN_CFG, PLAN_DRAIN } plan_kind_t;

	typedef struct {
		plan_kind_t    kind;
		req_t          item;
		logic [CW-1:0] cap;
	} plan_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	req_t          req       = '0;
	logic          rsp_ready = 1'b0;
	logic          cfg_valid = 1'b0;
	logic [CW-1:0] cfg_data  = '0;
	wire           req_ready;
	wire           rsp_valid;
	wire           cfg_ready;
	rsp_t          rsp;

	bounded_double_ended_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// deque model
	logic [31:0]   model_slots [DEPTH_DEF];
	logic [3:0]    model_head  = '0;
	logic [3:0]    model_tail  = '0;
	logic [CW-1:0] model_count = '0;
	logic [CW-1:0] model_cap   = CAP_RESET;

	plan_t op_plan [$];
	rsp_t  status_q [$];

	int error_count = 0;
	int cycle_count = 0;
	int send_gap    = 0;
	int send_burst  = 0;
	int recv_stall  = 0;
	int recv_burst  = 0;
	int settle      = 0;

	function automatic rsp_t apply_deque_op(req_t r);
		rsp_t          s;
		logic [CW-1:0] lim;
		logic [3:0]    last;
		lim = (model_cap > CW'(DEPTH_DEF)) ? CW'(DEPTH_DEF) : model_cap;
		s = '0;
		case (r.op)
			OP_INS_FRONT: begin
				if (model_count < lim) begin
					model_head = model_head - 4'd1;
					model_slots[model_head] = r.value;
					model_count++;
					s.success = 1'b1;
				end
			end
			OP_INS_BACK: begin
				if (model_count < lim) begin
					model_slots[model_tail] = r.value;
					model_tail = model_tail + 4'd1;
					model_count++;
					s.success = 1'b1;
				end
			end
			OP_DEL_FRONT: begin
				if (model_count != 0) begin
					model_head = model_head + 4'd1;
					model_count--;
					s.success = 1'b1;
				end
			end
			OP_DEL_BACK: begin
				if (model_count != 0) begin
					model_tail = model_tail - 4'd1;
					model_count--;
					s.success = 1'b1;
				end
			end
			default: ;
		endcase
		last = model_tail - 4'd1;
		if (model_count != 0) begin
			s.front_value = model_slots[model_head];
			s.rear_value  = model_slots[last];
		end else begin
			s.front_value = '1;
			s.rear_value  = '1;
		end
		s.is_empty  = (model_count == 0);
		s.is_full   = (model_count >= lim);
		s.occupancy = model_count;
		return s;
	endfunction

	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic add_op(logic [2:0] op, logic [31:0] value);
		plan_t p;
		p.kind       = PLAN_OP;
		p.item.op    = op;
		p.item.value = value;
		p.cap        = '0;
		op_plan.push_back(p);
	endtask

	task automatic add_cfg(logic [CW-1:0] cap);
		plan_t p;
		p.kind = PLAN_CFG;
		p.item = '0;
		p.cap  = cap;
		op_plan.push_back(p);
	endtask

	task automatic add_drain();
		plan_t p;
		p.kind = PLAN_DRAIN;
		p.item = '0;
		p.cap  = '0;
		op_plan.push_back(p);
	endtask

	// stretches that lean toward filling or draining, with some noise
	task automatic add_random_ops(int n);
		int         left;
		bit         filling;
		bit         ins;
		int         r;
		logic [2:0] op;
		left    = 0;
		filling = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				filling = $urandom_range(0, 1);
				left    = $urandom_range(4, 20);
			end
			left--;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				op = ($urandom_range(0, 1) == 0) ? OP_NONE : 3'($urandom_range(OP_RSV5, OP_RSV7));
			end else begin
				ins = (r < 80) ? filling : !filling;
				if (ins)
					op = ($urandom_range(0, 1) == 0) ? OP_INS_FRONT : OP_INS_BACK;
				else
					op = ($urandom_range(0, 1) == 0) ? OP_DEL_FRONT : OP_DEL_BACK;
			end
			add_op(op, pick_value());
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		logic  nxt_valid;
		logic  nxt_cfg;
		plan_t p;
		if (arst_n) begin
			nxt_valid = req_valid;
			nxt_cfg   = cfg_valid;
			if (req_valid && req_ready) begin
				status_q.push_back(apply_deque_op(req));
				nxt_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				model_cap = cfg_data;
				nxt_cfg   = 1'b0;
			end
			if (status_q.size() != 0 || nxt_valid || nxt_cfg)
				settle = 0;
			else if (settle < HOLD)
				settle++;
			if (!nxt_valid && !nxt_cfg) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (op_plan.size() != 0) begin
					if (op_plan[0].kind == PLAN_OP) begin
						p         = op_plan.pop_front();
						req      <= p.item;
						nxt_valid = 1'b1;
						send_gap  = draw_wait(send_burst);
					end else if (settle >= HOLD) begin
						p = op_plan.pop_front();
						if (p.kind == PLAN_CFG) begin
							cfg_data <= p.cap;
							nxt_cfg   = 1'b1;
						end
						settle = 0;
					end
				end
			end
			req_valid <= nxt_valid;
			cfg_valid <= nxt_cfg;
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (status_q.size() == 0) begin
					report_mismatch("unexpected response, front", rsp.front_value, '0);
				end else begin
					want = status_q.pop_front();
					check_field("success", 32'(rsp.success), 32'(want.success));
					check_field("front_value", rsp.front_value, want.front_value);
					check_field("rear_value", rsp.rear_value, want.rear_value);
					check_field("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
					check_field("is_full", 32'(rsp.is_full), 32'(want.is_full));
					check_field("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
				end
				recv_stall = draw_wait(recv_burst);
				rsp_ready <= (recv_stall == 0);
			end else if (!rsp_ready) begin
				if (recv_stall > 0)
					recv_stall--;
				if (recv_stall == 0)
					rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [CW-1:0] caps [10];
		caps = '{5'd16, 5'd1, 5'd2, 5'd17, 5'd0, 5'd4, 5'd16, 5'd9, 5'd31, 5'd16};

		// empty queue at reset capacity
		add_op(OP_NONE, $urandom);
		add_op(OP_DEL_FRONT, 32'h1234_5678);
		add_op(OP_DEL_BACK, 32'h8765_4321);
		add_op(OP_INS_FRONT, 32'h7fff_ffff);
		add_op(OP_INS_BACK, 32'h8000_0000);
		add_op(OP_INS_FRONT, 32'hffff_ffff);
		add_op(OP_INS_BACK, 32'h0000_0000);
		add_op(OP_RSV5, 32'haaaa_aaaa);
		add_op(OP_RSV6, 32'h5555_5555);
		add_op(OP_RSV7, 32'h0000_0000);
		add_op(OP_DEL_FRONT, 32'h0);
		add_op(OP_DEL_BACK, 32'h0);
		// capacity below the count held
		add_cfg(5'd1);
		add_op(OP_INS_BACK, 32'h0bad_cafe);
		add_op(OP_DEL_BACK, 32'h0);
		add_op(OP_INS_FRONT, 32'h0bad_f00d);
		add_op(OP_INS_BACK, 32'hdead_beef);
		// zero capacity: empty and full together
		add_cfg(5'd0);
		add_op(OP_DEL_FRONT, 32'h0);
		add_op(OP_INS_BACK, 32'h1111_1111);
		add_op(OP_INS_FRONT, 32'h2222_2222);
		add_op(OP_NONE, 32'h0);
		// capacity above depth saturates
		add_cfg(5'd31);
		add_op(OP_INS_BACK, 32'h0000_0001);
		add_op(OP_INS_FRONT, 32'hffff_fffe);
		add_op(OP_DEL_BACK, 32'h0);

		for (int k = 0; k < 10; k++) begin
			add_cfg(caps[k]);
			if (k == 3) begin
				add_random_ops(22);
				add_drain();
				add_random_ops(23);
			end else begin
				add_random_ops(45);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (op_plan.size() != 0 || req_valid || cfg_valid || status_q.size() != 0);
		repeat (TAIL) @(negedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
